FILE: src/mswo_pkg.sv
package mswo_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SAMPLE_BITS_MAX     = 24;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int AMP_W       = 15;
    localparam int SHAPE_W     = 2;
    localparam int OUT_W       = 16;

    // pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE,
        SHAPE_SAW,
        SHAPE_SQUARE,
        SHAPE_TRIANGLE
    } shape_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE,
        REG_PHASE_STEP,
        REG_AMPLITUDE,
        REG_WAVE_SHAPE
    } reg_index_t;

    // Quarter-wave sine entry k of a table with 2^addr_bits steps, full scale
    // 2^(sample_bits-1)-1. Taylor series in Q30 through x^13, rounded half up.
    // Only ever evaluated on constants, so it folds into a ROM.
    function automatic logic [SAMPLE_BITS_MAX-1:0] sine_entry(
        input int unsigned k,
        input int unsigned addr_bits,
        input int unsigned sample_bits
    );
        logic [63:0] x;
        logic [63:0] xx;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] fs;
        longint      s;
        fs = (64'd1 << (sample_bits - 1)) - 64'd1;
        x  = (64'(k) * HALF_PI_Q30) >> addr_bits;
        xx = (x * x) >> 30;
        s  = longint'(x);
        t  = ((x * xx) >> 30) / 64'd6;
        s  = s - longint'(t);
        t  = ((t * xx) >> 30) / 64'd20;
        s  = s + longint'(t);
        t  = ((t * xx) >> 30) / 64'd42;
        s  = s - longint'(t);
        t  = ((t * xx) >> 30) / 64'd72;
        s  = s + longint'(t);
        t  = ((t * xx) >> 30) / 64'd110;
        s  = s - longint'(t);
        t  = ((t * xx) >> 30) / 64'd156;
        s  = s + longint'(t);
        if (s < 0)
            s = 0;
        if (s > (longint'(1) << 30))
            s = longint'(1) << 30;
        v = (64'(s) * fs + (64'd1 << 29)) >> 30;
        if (v > fs)
            v = fs;
        return v[SAMPLE_BITS_MAX-1:0];
    endfunction

endpackage

FILE: src/mswo_phase.sv
module mswo_phase #(
    parameter int PHASE_BITS = mswo_pkg::PHASE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        restart,
    input  logic                        enable,
    input  logic [mswo_pkg::STEP_W-1:0] phase_step,
    output logic                        s1_valid,
    input  logic                        s1_ready,
    output logic [PHASE_BITS-1:0]       s1_phase,
    output logic                        s1_err
);
    import mswo_pkg::*;

    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  valid_reg;
    logic                  err_reg;
    logic                  accept;

    assign in_ready = !valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // A disabled generator holds its phase, but restart still clears it.
    always_comb
    begin
        phase_next = restart ? '0 : acc_reg;
        acc_next   = enable ? phase_next + PHASE_BITS'(phase_step) : phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                acc_reg <= acc_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (s1_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            phase_reg <= phase_next;
            err_reg   <= !enable;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_phase = phase_reg;
    assign s1_err   = err_reg;

endmodule

FILE: src/mswo_shape.sv
module mswo_shape #(
    parameter int PHASE_BITS      = mswo_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = mswo_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = mswo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mswo_pkg::shape_t       wave_shape,
    input  logic                   s1_valid,
    output logic                   s1_ready,
    input  logic [PHASE_BITS-1:0]  s1_phase,
    input  logic                   s1_err,
    output logic                   s2_valid,
    input  logic                   s2_ready,
    output logic [SAMPLE_BITS-2:0] s2_mag,
    output logic                   s2_neg,
    output logic                   s2_err
);
    import mswo_pkg::*;

    localparam int ROM_N = 1 << TABLE_ADDR_BITS;
    localparam int AB    = TABLE_ADDR_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int WW    = SAMPLE_BITS + 3;

    localparam logic signed [WW-1:0] HALF = WW'(1) <<< (SB - 1);
    localparam logic signed [WW-1:0] FS   = HALF - WW'(1);

    logic [SB-2:0]        rom_tbl [0:ROM_N];
    logic [SB-2:0]        rom_reg;
    logic [SB-2:0]        mag_reg;
    logic [SB-2:0]        mag_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic                 sine_reg;
    logic                 err_reg;
    logic                 valid_reg;
    logic                 load;
    logic [1:0]           quad;
    logic [AB-1:0]        addr_lo;
    logic [AB:0]          rom_addr;
    logic [SB-1:0]        u;
    logic signed [WW-1:0] u_s;
    logic signed [WW-1:0] w;

    for (genvar k = 0; k <= ROM_N; k++)
    begin : g_rom
        assign rom_tbl[k] = (SB - 1)'(sine_entry(k, AB, SB));
    end

    if (PHASE_BITS >= SAMPLE_BITS)
    begin : g_u_top
        assign u = s1_phase[PHASE_BITS-1 -: SAMPLE_BITS];
    end
    else
    begin : g_u_pad
        assign u = {s1_phase, (SAMPLE_BITS - PHASE_BITS)'(0)};
    end

    assign quad    = s1_phase[PHASE_BITS-1 -: 2];
    assign addr_lo = s1_phase[PHASE_BITS-3 -: AB];
    assign u_s     = signed'(WW'(u));

    // Second and fourth quadrants read the quarter wave mirrored.
    always_comb
    begin
        if (quad[0])
            rom_addr = (AB + 1)'(ROM_N) - {1'b0, addr_lo};
        else
            rom_addr = {1'b0, addr_lo};
    end

    always_comb
    begin
        case (wave_shape)
            SHAPE_SAW:
                w = u_s - HALF;
            SHAPE_SQUARE:
                w = u[SB-1] ? -FS : FS;
            SHAPE_TRIANGLE:
                w = u[SB-1] ? (HALF + HALF + HALF) - (u_s <<< 1) : (u_s <<< 1) - HALF;
            default:
                w = '0;
        endcase
        if (w > FS)
            w = FS;
        if (w < -FS)
            w = -FS;
        neg_next = w[WW-1];
        mag_next = (SB - 1)'(neg_next ? -w : w);
        if (wave_shape == SHAPE_SINE)
            neg_next = quad[1];
    end

    assign s1_ready = !valid_reg || s2_ready;
    assign load     = s1_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (s2_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rom_reg  <= rom_tbl[rom_addr];
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            sine_reg <= (wave_shape == SHAPE_SINE);
            err_reg  <= s1_err;
        end
    end

    assign s2_valid = valid_reg;
    assign s2_mag   = sine_reg ? rom_reg : mag_reg;
    assign s2_neg   = neg_reg;
    assign s2_err   = err_reg;

endmodule

FILE: src/mswo_scale.sv
module mswo_scale #(
    parameter int SAMPLE_BITS = mswo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mswo_pkg::AMP_W-1:0]          amplitude,
    input  logic                                s2_valid,
    output logic                                s2_ready,
    input  logic [SAMPLE_BITS-2:0]              s2_mag,
    input  logic                                s2_neg,
    input  logic                                s2_err,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mswo_pkg::OUT_W-1:0]   sample,
    output logic                                error
);
    import mswo_pkg::*;

    localparam int PW = SAMPLE_BITS + AMP_W;

    logic [PW-1:0]           prod;
    logic [OUT_W-1:0]        scaled;
    logic signed [OUT_W-1:0] sample_reg;
    logic signed [OUT_W-1:0] sample_next;
    logic                    error_reg;
    logic                    valid_reg;
    logic                    load;

    // Magnitude times amplitude, rounded half away from zero by working on |w|.
    always_comb
    begin
        prod        = PW'(s2_mag) * PW'(amplitude) + (PW'(1) << (SAMPLE_BITS - 2));
        scaled      = prod[SAMPLE_BITS-1 +: OUT_W];
        sample_next = s2_err ? '0 : signed'(s2_neg ? -scaled : scaled);
    end

    assign s2_ready = !valid_reg || out_ready;
    assign load     = s2_valid && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
            error_reg  <= s2_err;
        end
    end

    assign out_valid = valid_reg;
    assign sample    = sample_reg;
    assign error     = error_reg;

endmodule

FILE: src/multi_shape_waveform_oscillator.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    restart
// result    out_valid / out_ready  sample, error
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle sustained while out_ready is held high. A transaction
// passes the phase register, the registered sine ROM read and the scale and
// output register before it reaches the result port. The ROM read port sets
// the stage count. Reset (rst_n low) clears the phase accumulator, the
// configuration registers and all stage valid flags. Each stage holds while the
// one after it is full and stalled.
module multi_shape_waveform_oscillator #(
    parameter int PHASE_BITS      = mswo_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = mswo_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = mswo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mswo_pkg::OUT_W-1:0] sample,
    output logic                              error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mswo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mswo_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mswo_pkg::*;

    logic                   enable_reg;
    logic [STEP_W-1:0]      phase_step_reg;
    logic [AMP_W-1:0]       amplitude_reg;
    shape_t                 wave_shape_reg;

    logic                   s1_valid;
    logic                   s1_ready;
    logic [PHASE_BITS-1:0]  s1_phase;
    logic                   s1_err;
    logic                   s2_valid;
    logic                   s2_ready;
    logic [SAMPLE_BITS-2:0] s2_mag;
    logic                   s2_neg;
    logic                   s2_err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            phase_step_reg <= '0;
            amplitude_reg  <= '0;
            wave_shape_reg <= SHAPE_SINE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_W-1:0];
                REG_WAVE_SHAPE: wave_shape_reg <= shape_t'(cfg_data[SHAPE_W-1:0]);
                default:        ;
            endcase
        end
    end

    mswo_phase #(
        .PHASE_BITS(PHASE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .enable     (enable_reg),
        .phase_step (phase_step_reg),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_phase   (s1_phase),
        .s1_err     (s1_err)
    );

    mswo_shape #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .wave_shape (wave_shape_reg),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_phase   (s1_phase),
        .s1_err     (s1_err),
        .s2_valid   (s2_valid),
        .s2_ready   (s2_ready),
        .s2_mag     (s2_mag),
        .s2_neg     (s2_neg),
        .s2_err     (s2_err)
    );

    mswo_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .amplitude  (amplitude_reg),
        .s2_valid   (s2_valid),
        .s2_ready   (s2_ready),
        .s2_mag     (s2_mag),
        .s2_neg     (s2_neg),
        .s2_err     (s2_err),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .error      (error)
    );

`ifndef NO_ASSERTIONS
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> sample == '0)
        else $error("error result carries a nonzero sample");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != {1'b1, {(OUT_W - 1){1'b0}}})
        else $error("sample reached the most negative code");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> in_ready)
        else $error("input refused with an empty first stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !s2_ready |=> s2_valid)
        else $error("stalled transaction dropped between stages");
`endif

endmodule
